>>> hdl/msc_pkg.sv
// ============================================================================
// msc_pkg
// Shared types and constants of the snooping coherence block: line states,
// fill source codes, controller states and the snoop result bundle.
// ============================================================================
package msc_pkg;

    // parameter defaults
    localparam int CORE_COUNT_DEF     = 4;
    localparam int LINES_PER_CORE_DEF = 4;
    localparam int ADDR_BITS_DEF      = 16;

    // fixed field widths
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 32;
    localparam int CORE_IDX_W = 2;

    // value supplied by backing memory is address times this
    localparam int MEM_SCALE = 10;

    typedef enum logic [1:0] {
        LS_INVALID   = 2'd0,
        LS_SHARED    = 2'd1,
        LS_EXCLUSIVE = 2'd2,
        LS_MODIFIED  = 2'd3
    } line_state_t;

    typedef enum logic [1:0] {
        FILL_LOCAL = 2'd0,
        FILL_PEER  = 2'd1,
        FILL_MEM   = 2'd2
    } fill_src_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_QUOT,
        CS_INDEX,
        CS_READ,
        CS_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              was_miss;
        fill_src_t         fill_source;
        logic [1:0]        peers_invalidated;
    } snoop_res_t;

endpackage

>>> hdl/msc_line_ram.sv
// ============================================================================
// msc_line_ram
// Single-port-write, single-port-read synchronous memory holding one row per
// cache index: status, tag and data of every core's line at that index.
// ============================================================================
module msc_line_ram #(
    parameter int DEPTH  = msc_pkg::LINES_PER_CORE_DEF,
    parameter int ADDR_W = 2,
    parameter int WIDTH  = 200
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/msc_index_unit.sv
// ============================================================================
// msc_index_unit
// Two-stage address-to-index reduction: address modulo the line count,
// done by reciprocal multiply then multiply-back and subtract.
// ============================================================================
module msc_index_unit #(
    parameter int LINES_PER_CORE = msc_pkg::LINES_PER_CORE_DEF,
    parameter int TAG_W          = 16,
    parameter int IDX_W          = 2
) (
    input  logic             clk,
    input  logic [TAG_W-1:0] addr,
    output logic [IDX_W-1:0] idx
);

    // floor(2^32 / d) + 1 gives an exact quotient for numerators below 2^16
    localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) / 64'(LINES_PER_CORE)) + 64'd1);
    localparam int PROD_W = TAG_W + 33;
    localparam int QD_W   = TAG_W + 9;

    logic [PROD_W-1:0] prod;
    logic [TAG_W-1:0]  quot_reg;
    logic [TAG_W-1:0]  addr_d_reg;
    logic [QD_W-1:0]   qd;
    logic [QD_W-1:0]   rem;
    logic [IDX_W-1:0]  idx_reg;

    // stage 1: quotient estimate
    assign prod = PROD_W'(addr) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        quot_reg   <= prod[32 +: TAG_W];
        addr_d_reg <= addr;
    end

    // stage 2: remainder
    assign qd  = QD_W'(quot_reg) * QD_W'(LINES_PER_CORE);
    assign rem = QD_W'(addr_d_reg) - qd;

    always_ff @(posedge clk)
    begin
        idx_reg <= rem[IDX_W-1:0];
    end

    assign idx = idx_reg;

endmodule

>>> hdl/msc_snoop.sv
// ============================================================================
// msc_snoop
// Coherence decision for one access: looks at every core's line in the row,
// picks hit, peer supply or memory fill, invalidates peers on writes and
// builds the row to write back.
// ============================================================================
module msc_snoop #(
    parameter int CORE_COUNT = msc_pkg::CORE_COUNT_DEF,
    parameter int TAG_W      = 16,
    parameter int CORE_W     = 2
) (
    input  logic                                      row_valid,
    input  logic [CORE_COUNT-1:0][1:0]                status,
    input  logic [CORE_COUNT-1:0][TAG_W-1:0]          tag,
    input  logic [CORE_COUNT-1:0][msc_pkg::DATA_W-1:0] value,
    input  logic                                      is_write,
    input  logic [CORE_W-1:0]                         me,
    input  logic [TAG_W-1:0]                          tag_a,
    input  logic [msc_pkg::DATA_W-1:0]                write_data,
    input  logic [msc_pkg::DATA_W-1:0]                mem_value,
    output logic [CORE_COUNT-1:0][1:0]                new_status,
    output logic [CORE_COUNT-1:0][TAG_W-1:0]          new_tag,
    output logic [CORE_COUNT-1:0][msc_pkg::DATA_W-1:0] new_value,
    output logic [CORE_COUNT-1:0]                     inv_vec,
    output msc_pkg::snoop_res_t                       res
);

    always_comb
    begin
        logic [CORE_COUNT-1:0]      match;
        logic [CORE_COUNT-1:0][1:0] cur;
        logic                       found;
        logic [CORE_W-1:0]          src_c;
        logic [4:0]                 n_inv;

        // current states; a row never written reads as all invalid
        for (int c = 0; c < CORE_COUNT; c++)
        begin
            cur[c]   = row_valid ? status[c] : msc_pkg::LS_INVALID;
            match[c] = (cur[c] != msc_pkg::LS_INVALID) && (tag[c] == tag_a);
        end

        new_status = cur;
        new_tag    = tag;
        new_value  = value;
        inv_vec    = '0;
        res        = '0;
        found      = 1'b0;
        src_c      = '0;
        n_inv      = '0;

        if (!is_write)
        begin
            if (match[me])
            begin
                // read hit
                res.read_value = value[me];
            end
            else
            begin
                // read miss: first matching peer in core order supplies
                res.was_miss = 1'b1;
                for (int c = 0; c < CORE_COUNT; c++)
                begin
                    if (!found && (CORE_W'(c) != me) && match[c])
                    begin
                        found = 1'b1;
                        src_c = CORE_W'(c);
                    end
                end
                if (found)
                begin
                    new_status[src_c] = msc_pkg::LS_SHARED;
                    new_status[me]    = msc_pkg::LS_SHARED;
                    new_value[me]     = value[src_c];
                    res.fill_source   = msc_pkg::FILL_PEER;
                end
                else
                begin
                    new_status[me]  = msc_pkg::LS_EXCLUSIVE;
                    new_value[me]   = mem_value;
                    res.fill_source = msc_pkg::FILL_MEM;
                end
                new_tag[me]    = tag_a;
                res.read_value = new_value[me];
            end
        end
        else
        begin
            // write: invalidate peers unless already owned
            if (!(match[me] && (cur[me] != msc_pkg::LS_SHARED)))
            begin
                for (int c = 0; c < CORE_COUNT; c++)
                begin
                    if ((CORE_W'(c) != me) && match[c])
                    begin
                        inv_vec[c]    = 1'b1;
                        new_status[c] = msc_pkg::LS_INVALID;
                        n_inv         = n_inv + 5'd1;
                    end
                end
            end
            if (!match[me])
            begin
                res.was_miss = 1'b1;
            end
            new_tag[me]            = tag_a;
            new_value[me]          = write_data;
            new_status[me]         = msc_pkg::LS_MODIFIED;
            res.peers_invalidated  = (n_inv > 5'd3) ? 2'd3 : n_inv[1:0];
        end
    end

endmodule

>>> hdl/mesi_snoop_coherence.sv
// ============================================================================
// mesi_snoop_coherence
// Snooping MESI-style coherence over several private direct-mapped caches,
// with per-core saturating miss and invalidation counters.
// ============================================================================
// Usage:
//   A request (action, core_index, addr, write_data) is a valid/ready transfer
//   on req_valid/req_ready; each request yields exactly one response transfer
//   on rsp_valid/rsp_ready carrying read_value, was_miss, fill_source,
//   peers_invalidated and the issuing core's two counters.
//   The line state of all cores at one index lives in one memory row. A
//   request passes states CS_QUOT and CS_INDEX to reduce the address to an
//   index (reciprocal multiply, then multiply-back), CS_READ for the row
//   read and CS_UPDATE to decide, write the row back and register the
//   response. The controller handles one request at a time: it takes a
//   new request only once the last response has been registered.
//   The request side is ready again as soon as the response is registered,
//   even while that response still waits. If the receiver stalls, the next
//   request holds in its final step until the output register frees.
//   Reset clears the per-row valid bits, so every line reads Invalid, and
//   zeroes all counters; no clearing pass over the memory is needed.
//   A core_index at or above CORE_COUNT changes nothing and returns zeros.
// ============================================================================
module mesi_snoop_coherence #(
    parameter int CORE_COUNT     = msc_pkg::CORE_COUNT_DEF,
    parameter int LINES_PER_CORE = msc_pkg::LINES_PER_CORE_DEF,
    parameter int ADDR_BITS      = msc_pkg::ADDR_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  logic                                 action,
    input  logic [msc_pkg::CORE_IDX_W-1:0]       core_index,
    input  logic [msc_pkg::ADDR_W-1:0]           addr,
    input  logic signed [msc_pkg::DATA_W-1:0]    write_data,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output logic signed [msc_pkg::DATA_W-1:0]    read_value,
    output logic                                 was_miss,
    output logic [1:0]                           fill_source,
    output logic [1:0]                           peers_invalidated,
    output logic [msc_pkg::DATA_W-1:0]           requester_misses,
    output logic [msc_pkg::DATA_W-1:0]           requester_invalidations
);

    localparam int DW     = msc_pkg::DATA_W;
    localparam int TAG_W  = (ADDR_BITS < msc_pkg::ADDR_W) ? ADDR_BITS : msc_pkg::ADDR_W;
    localparam int CORE_W = $clog2(CORE_COUNT);
    localparam int IDX_W  = (LINES_PER_CORE > 1) ? $clog2(LINES_PER_CORE) : 1;
    localparam int ROW_W  = CORE_COUNT * (2 + TAG_W + DW);

    // controller state
    msc_pkg::ctrl_state_t state_reg, state_next;
    logic                 commit;
    logic                 ram_we;

    // captured request
    logic              write_reg;
    logic [1:0]        core_reg;
    logic              me_ok_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [DW-1:0]     wdata_reg;
    logic [CORE_W-1:0] me;
    logic [DW-1:0]     mem_value;

    // row storage
    logic [IDX_W-1:0]                   idx;
    logic [LINES_PER_CORE-1:0]          row_valid_reg, row_valid_next;
    logic [ROW_W-1:0]                   rd_row, wr_row;
    logic [CORE_COUNT-1:0][1:0]         rd_status, wr_status;
    logic [CORE_COUNT-1:0][TAG_W-1:0]   rd_tag, wr_tag;
    logic [CORE_COUNT-1:0][DW-1:0]      rd_value, wr_value;
    logic [CORE_COUNT-1:0]              inv_vec;
    msc_pkg::snoop_res_t                res;

    // counters
    logic [CORE_COUNT-1:0][DW-1:0] miss_cnt_reg, miss_cnt_next;
    logic [CORE_COUNT-1:0][DW-1:0] inv_cnt_reg, inv_cnt_next;

    // response register
    logic                rsp_valid_reg, rsp_valid_next;
    logic [DW-1:0]       read_value_reg;
    logic                was_miss_reg;
    msc_pkg::fill_src_t  fill_reg;
    logic [1:0]          peers_inv_reg;
    logic [DW-1:0]       req_miss_reg;
    logic [DW-1:0]       req_inv_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            write_reg <= action;
            core_reg  <= core_index;
            me_ok_reg <= (int'(core_index) < CORE_COUNT);
            tag_reg   <= addr[TAG_W-1:0];
            wdata_reg <= write_data;
        end
    end

    assign me        = CORE_W'(core_reg);
    assign mem_value = DW'(tag_reg) * DW'(msc_pkg::MEM_SCALE);

    msc_index_unit #(
        .LINES_PER_CORE (LINES_PER_CORE),
        .TAG_W          (TAG_W),
        .IDX_W          (IDX_W)
    ) u_index (
        .clk  (clk),
        .addr (tag_reg),
        .idx  (idx)
    );

    msc_line_ram #(
        .DEPTH  (LINES_PER_CORE),
        .ADDR_W (IDX_W),
        .WIDTH  (ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (wr_row),
        .raddr (idx),
        .rdata (rd_row)
    );

    assign {rd_status, rd_tag, rd_value} = rd_row;
    assign wr_row = {wr_status, wr_tag, wr_value};

    msc_snoop #(
        .CORE_COUNT (CORE_COUNT),
        .TAG_W      (TAG_W),
        .CORE_W     (CORE_W)
    ) u_snoop (
        .row_valid  (row_valid_reg[idx]),
        .status     (rd_status),
        .tag        (rd_tag),
        .value      (rd_value),
        .is_write   (write_reg),
        .me         (me),
        .tag_a      (tag_reg),
        .write_data (wdata_reg),
        .mem_value  (mem_value),
        .new_status (wr_status),
        .new_tag    (wr_tag),
        .new_value  (wr_value),
        .inv_vec    (inv_vec),
        .res        (res)
    );

    // controller state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msc_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and handshake
    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            msc_pkg::CS_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    state_next = msc_pkg::CS_QUOT;
                end
            end
            msc_pkg::CS_QUOT:
            begin
                state_next = msc_pkg::CS_INDEX;
            end
            msc_pkg::CS_INDEX:
            begin
                state_next = msc_pkg::CS_READ;
            end
            msc_pkg::CS_READ:
            begin
                state_next = msc_pkg::CS_UPDATE;
            end
            msc_pkg::CS_UPDATE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    commit     = 1'b1;
                    state_next = msc_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = msc_pkg::CS_IDLE;
            end
        endcase
    end

    assign ram_we = commit && me_ok_reg;

    // row valid bits and saturating counters
    always_comb
    begin
        row_valid_next = row_valid_reg;
        miss_cnt_next  = miss_cnt_reg;
        inv_cnt_next   = inv_cnt_reg;
        if (ram_we)
        begin
            row_valid_next[idx] = 1'b1;
            if (res.was_miss && (miss_cnt_reg[me] != '1))
            begin
                miss_cnt_next[me] = miss_cnt_reg[me] + DW'(1);
            end
            for (int c = 0; c < CORE_COUNT; c++)
            begin
                if (inv_vec[c] && (inv_cnt_reg[c] != '1))
                begin
                    inv_cnt_next[c] = inv_cnt_reg[c] + DW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            miss_cnt_reg  <= '0;
            inv_cnt_reg   <= '0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            miss_cnt_reg  <= miss_cnt_next;
            inv_cnt_reg   <= inv_cnt_next;
        end
    end

    // response transfer register
    assign rsp_valid_next = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            if (me_ok_reg)
            begin
                read_value_reg <= res.read_value;
                was_miss_reg   <= res.was_miss;
                fill_reg       <= res.fill_source;
                peers_inv_reg  <= res.peers_invalidated;
                req_miss_reg   <= miss_cnt_next[me];
                req_inv_reg    <= inv_cnt_next[me];
            end
            else
            begin
                read_value_reg <= '0;
                was_miss_reg   <= 1'b0;
                fill_reg       <= msc_pkg::FILL_LOCAL;
                peers_inv_reg  <= '0;
                req_miss_reg   <= '0;
                req_inv_reg    <= '0;
            end
        end
    end

    assign rsp_valid               = rsp_valid_reg;
    assign read_value              = read_value_reg;
    assign was_miss                = was_miss_reg;
    assign fill_source             = fill_reg;
    assign peers_invalidated       = peers_inv_reg;
    assign requester_misses        = req_miss_reg;
    assign requester_invalidations = req_inv_reg;

    // a row written back is valid from then on
    a_row_valid_after_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        ram_we |=> row_valid_reg[$past(idx)]
    ) else $error("row not marked valid after write-back");

    // a requester never invalidates its own line
    a_no_self_invalidate: assert property (
        @(posedge clk) disable iff (!rst_n)
        ram_we |-> !inv_vec[me]
    ) else $error("requester's own line invalidated");

    // a fill from peer or memory is always a miss
    a_fill_is_miss: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && (fill_source != msc_pkg::FILL_LOCAL)) |-> was_miss
    ) else $error("fill reported without a miss");

    // a counted miss leaves a nonzero miss count in the response
    a_miss_counted: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ram_we && res.was_miss) |=> (requester_misses != '0)
    ) else $error("miss not reflected in requester_misses");

endmodule

>>> bench/tb_mesi_snoop_coherence.sv
// ----------------------------------------------------------------------------
// tb_mesi_snoop_coherence
// Self-checking bench for the snooping coherence block. Every accepted access
// is run through a local copy of the four caches and counters; each response
// is compared field by field with the oldest pending outcome. A short
// directed table comes first, then random traffic mostly over a small set of hot
// addresses under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mesi_snoop_coherence;

    localparam int CORE_N      = msc_pkg::CORE_COUNT_DEF;
    localparam int NUM_LINES   = msc_pkg::LINES_PER_CORE_DEF;
    localparam int TOTAL_LINES = CORE_N * NUM_LINES;
    localparam logic [31:0] ADDR_MASK = (32'd1 << msc_pkg::ADDR_BITS_DEF) - 32'd1;
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;
    localparam int PHASE_ITEMS = 408;
    localparam int N_DIR       = 20;

    typedef struct packed {
        logic [31:0]        read_value;
        logic               was_miss;
        msc_pkg::fill_src_t fill_source;
        logic [1:0]         peers_invalidated;
        logic [31:0]        misses;
        logic [31:0]        invals;
    } coh_result_t;

    typedef struct packed {
        logic        act;
        logic [1:0]  core;
        logic [15:0] addr;
        logic [31:0] wd;
        logic        typed;
        coh_result_t want;
    } dir_row_t;

    // directed accesses; typed rows carry a fixed expected outcome instead of the local copy's
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{ACT_READ,  2'd0, 16'h0000, 32'h0, 1'b1,
          '{32'd0, 1'b1, msc_pkg::FILL_MEM, 2'd0, 32'd1, 32'd0}},
        '{ACT_READ,  2'd3, 16'hFFFF, 32'h0, 1'b1,
          '{32'd655350, 1'b1, msc_pkg::FILL_MEM, 2'd0, 32'd1, 32'd0}},
        '{ACT_READ,  2'd0, 16'h0000, 32'h0, 1'b1,
          '{32'd0, 1'b0, msc_pkg::FILL_LOCAL, 2'd0, 32'd1, 32'd0}},
        '{ACT_READ,  2'd1, 16'h0000, 32'h0,         1'b0, '0},
        '{ACT_READ,  2'd2, 16'h0000, 32'h0,         1'b0, '0},
        '{ACT_WRITE, 2'd3, 16'h0000, 32'h7FFFFFFF,  1'b0, '0},
        '{ACT_READ,  2'd0, 16'h0000, 32'h0,         1'b0, '0},
        '{ACT_WRITE, 2'd0, 16'h0000, 32'h80000000,  1'b0, '0},
        '{ACT_WRITE, 2'd0, 16'h0000, 32'hFFFFFFFF,  1'b0, '0},
        '{ACT_READ,  2'd0, 16'h0004, 32'h0,         1'b0, '0},
        '{ACT_WRITE, 2'd0, 16'h0004, 32'h00000000,  1'b0, '0},
        '{ACT_READ,  2'd1, 16'h0004, 32'h0,         1'b0, '0},
        '{ACT_WRITE, 2'd2, 16'h0008, 32'h80000000,  1'b0, '0},
        '{ACT_READ,  2'd3, 16'hFFFF, 32'h0,         1'b0, '0},
        '{ACT_WRITE, 2'd3, 16'hFFFF, 32'h7FFFFFFF,  1'b0, '0},
        '{ACT_READ,  2'd1, 16'h0000, 32'hFFFFFFFF,  1'b0, '0},
        '{ACT_READ,  2'd2, 16'h0008, 32'h0,         1'b0, '0},
        '{ACT_READ,  2'd1, 16'hFFFF, 32'h0,         1'b0, '0},
        '{ACT_WRITE, 2'd0, 16'hAAAA, 32'h55555555,  1'b0, '0},
        '{ACT_READ,  2'd1, 16'hAAAA, 32'hAAAAAAAA,  1'b0, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic               action;
    logic [1:0]         core_index;
    logic [15:0]        addr;
    logic signed [31:0] write_data;
    logic               rsp_valid;
    logic               rsp_ready;
    logic signed [31:0] read_value;
    logic               was_miss;
    logic [1:0]         fill_source;
    logic [1:0]         peers_invalidated;
    logic [31:0]        requester_misses;
    logic [31:0]        requester_invalidations;

    // local copy of the caches and counters
    msc_pkg::line_state_t line_st  [TOTAL_LINES];
    logic [31:0]          line_tag [TOTAL_LINES];
    logic [31:0]          line_val [TOTAL_LINES];
    logic [31:0]          miss_cnt [CORE_N];
    logic [31:0]          inv_cnt  [CORE_N];

    coh_result_t access_outcomes [$];

    int send_idle_pct;
    int stall_pct;
    int mismatches;
    int n_results;
    int n_reads;
    int n_writes;
    int n_peer_fills;
    int n_mem_fills;
    int n_peer_drops;

    mesi_snoop_coherence dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .req_valid               (req_valid),
        .req_ready               (req_ready),
        .action                  (action),
        .core_index              (core_index),
        .addr                    (addr),
        .write_data              (write_data),
        .rsp_valid               (rsp_valid),
        .rsp_ready               (rsp_ready),
        .read_value              (read_value),
        .was_miss                (was_miss),
        .fill_source             (fill_source),
        .peers_invalidated       (peers_invalidated),
        .requester_misses        (requester_misses),
        .requester_invalidations (requester_invalidations)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
    endfunction

    function automatic bit line_hit(int slot, logic [31:0] a);
        return line_st[slot] != msc_pkg::LS_INVALID && line_tag[slot] == a;
    endfunction

    // apply one access to the local caches and work out its response
    task automatic resolve_access(input logic act, input logic [1:0] core,
                                  input logic [15:0] addr_in, input logic [31:0] wdata,
                                  output coh_result_t res);
        logic [31:0] a;
        int idx;
        int own;
        int slot;
        int n_inv;
        bit own_hit;
        bit found;
        res = '0;
        a = {16'd0, addr_in} & ADDR_MASK;
        if (int'(core) < CORE_N)
        begin
            idx = int'(a % NUM_LINES);
            own = int'(core) * NUM_LINES + idx;
            own_hit = line_hit(own, a);
            if (act == ACT_READ)
            begin
                if (own_hit)
                begin
                    res.read_value = line_val[own];
                end
                else
                begin
                    // snoop peers in core order, first valid match supplies data
                    res.was_miss = 1'b1;
                    miss_cnt[core] = sat_inc(miss_cnt[core]);
                    found = 1'b0;
                    for (int c = 0; c < CORE_N; c++)
                    begin
                        slot = c * NUM_LINES + idx;
                        if (!found && c != int'(core) && line_hit(slot, a))
                        begin
                            line_st[slot] = msc_pkg::LS_SHARED;
                            line_val[own] = line_val[slot];
                            line_st[own] = msc_pkg::LS_SHARED;
                            found = 1'b1;
                        end
                    end
                    if (found)
                    begin
                        res.fill_source = msc_pkg::FILL_PEER;
                    end
                    else
                    begin
                        line_val[own] = a * msc_pkg::MEM_SCALE;
                        line_st[own] = msc_pkg::LS_EXCLUSIVE;
                        res.fill_source = msc_pkg::FILL_MEM;
                    end
                    line_tag[own] = a;
                    res.read_value = line_val[own];
                end
            end
            else
            begin
                // shared hit or miss: drop every valid peer copy of the address
                if (!(own_hit && line_st[own] != msc_pkg::LS_SHARED))
                begin
                    if (!own_hit)
                    begin
                        res.was_miss = 1'b1;
                        miss_cnt[core] = sat_inc(miss_cnt[core]);
                    end
                    n_inv = 0;
                    for (int c = 0; c < CORE_N; c++)
                    begin
                        slot = c * NUM_LINES + idx;
                        if (c != int'(core) && line_hit(slot, a))
                        begin
                            line_st[slot] = msc_pkg::LS_INVALID;
                            inv_cnt[c] = sat_inc(inv_cnt[c]);
                            n_inv++;
                        end
                    end
                    res.peers_invalidated = (n_inv > 3) ? 2'd3 : 2'(n_inv);
                    line_tag[own] = a;
                end
                line_val[own] = wdata;
                line_st[own] = msc_pkg::LS_MODIFIED;
            end
            res.misses = miss_cnt[core];
            res.invals = inv_cnt[core];
        end
    endtask

    // one request transfer; the outcome is queued once it is accepted
    task automatic issue_access(input logic act, input logic [1:0] core,
                                input logic [15:0] a, input logic [31:0] wd,
                                input logic typed, input coh_result_t want);
        coh_result_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        action     <= act;
        core_index <= core;
        addr       <= a;
        write_data <= wd;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        resolve_access(act, core, a, wd, res);
        access_outcomes.push_back(typed ? want : res);
        if (act == ACT_READ)
            n_reads++;
        else
            n_writes++;
        if (res.fill_source == msc_pkg::FILL_PEER)
            n_peer_fills++;
        if (res.fill_source == msc_pkg::FILL_MEM)
            n_mem_fills++;
        n_peer_drops += int'(res.peers_invalidated);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at response %0d: %s got %08h want %08h", n_results, what, got, want);
        mismatches++;
    endtask

    // receiver stalls
    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

    // response check against the oldest pending outcome
    always @(posedge clk)
    begin
        coh_result_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (access_outcomes.size() == 0)
            begin
                report_mismatch("response with nothing pending", read_value, 32'd0);
            end
            else
            begin
                e = access_outcomes.pop_front();
                if (read_value !== e.read_value)
                    report_mismatch("read_value", read_value, e.read_value);
                if (was_miss !== e.was_miss)
                    report_mismatch("was_miss", 32'(was_miss), 32'(e.was_miss));
                if (fill_source !== e.fill_source)
                    report_mismatch("fill_source", 32'(fill_source), 32'(e.fill_source));
                if (peers_invalidated !== e.peers_invalidated)
                    report_mismatch("peers_invalidated", 32'(peers_invalidated),
                                    32'(e.peers_invalidated));
                if (requester_misses !== e.misses)
                    report_mismatch("requester_misses", requester_misses, e.misses);
                if (requester_invalidations !== e.invals)
                    report_mismatch("requester_invalidations", requester_invalidations,
                                    e.invals);
            end
            n_results++;
        end
    end

    // stimulus
    initial
    begin
        logic [15:0] hot [8];
        logic [15:0] a;
        logic [31:0] wd;
        int r;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        action        = ACT_READ;
        core_index    = 2'd0;
        addr          = 16'd0;
        write_data    = 32'sd0;
        rsp_ready     = 1'b1;
        send_idle_pct = 0;
        stall_pct     = 0;
        mismatches    = 0;
        n_results     = 0;
        n_reads       = 0;
        n_writes      = 0;
        n_peer_fills  = 0;
        n_mem_fills   = 0;
        n_peer_drops  = 0;
        for (int i = 0; i < TOTAL_LINES; i++)
        begin
            line_st[i]  = msc_pkg::LS_INVALID;
            line_tag[i] = 32'd0;
            line_val[i] = 32'd0;
        end
        for (int i = 0; i < CORE_N; i++)
        begin
            miss_cnt[i] = 32'd0;
            inv_cnt[i]  = 32'd0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_DIR; i++)
            issue_access(DIR_ROWS[i].act, DIR_ROWS[i].core, DIR_ROWS[i].addr,
                         DIR_ROWS[i].wd, DIR_ROWS[i].typed, DIR_ROWS[i].want);

        // random traffic, mostly on a few hot addresses so lines get shared
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 52; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 52; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            for (int k = 0; k < 8; k++)
                hot[k] = 16'($urandom_range(0, 65535));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // hold off until the block has drained
                if (i == PHASE_ITEMS / 2)
                begin
                    req_valid <= 1'b0;
                    @(posedge clk);
                    while (access_outcomes.size() != 0)
                        @(posedge clk);
                end
                r = $urandom_range(0, 99);
                if (r < 70)
                    a = hot[$urandom_range(0, 7)];
                else if (r < 90)
                    a = 16'($urandom_range(0, 15));
                else
                    a = 16'($urandom_range(0, 65535));
                r = $urandom_range(0, 99);
                if (r < 10)
                    wd = 32'h7FFFFFFF;
                else if (r < 20)
                    wd = 32'h80000000;
                else if (r < 25)
                    wd = 32'h00000000;
                else if (r < 30)
                    wd = 32'hFFFFFFFF;
                else
                    wd = $urandom;
                issue_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), a, wd,
                             1'b0, '0);
            end
        end

        // drain
        req_valid <= 1'b0;
        @(posedge clk);
        while (access_outcomes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d accesses: %0d reads, %0d writes, %0d peer fills, %0d memory fills",
                 n_reads + n_writes, n_reads, n_writes, n_peer_fills, n_mem_fills);
        $display("%0d peer copies dropped, %0d responses checked over four idle/stall mixes",
                 n_peer_drops, n_results);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
